/* hw/rtl/ldrs_pkg.sv */
// ----------------------------------------------------------------------------
// ldrs_pkg
// shared types and constants for the look disk request selector
// ----------------------------------------------------------------------------
package ldrs_pkg;

  localparam int SECTOR_W = 16;
  localparam int IDX_W    = 4;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // one slot as it leaves the read stage
  typedef struct packed {
    logic             vld;
    logic             waiting;
    logic [IDX_W-1:0] idx;
  } sample_t;

  // running best candidates on each side of the head
  typedef struct packed {
    logic             have_up;
    logic             have_down;
    logic [IDX_W-1:0] up_idx;
    logic [IDX_W-1:0] down_idx;
  } cand_t;

endpackage

/* hw/rtl/look_disk_request_selector.sv */
// ----------------------------------------------------------------------------
// look_disk_request_selector
// LOOK scheduling over a pool of disk requests
// ----------------------------------------------------------------------------
// A write request sets or clears one pool slot and gives no result. A select
// request scans every slot through the single read port of the sector
// memory, one slot per cycle. The input stays stalled after the select is
// taken, through the scan state, the drain state for the last memory read
// and the finish state that loads the result, and longer while an earlier
// result still waits. The result then sits in an output register until the
// far side takes it, while writes and a new select may already go ahead.
// The result is the nearest waiting sector in the sweep direction (inward
// candidates limited to disk_size), the other side when only it has one, or
// the fallback index with used_fallback set. Equal sectors favour the lowest
// slot; a slot at the head is never chosen. The user must write disk_size
// through the cfg channel only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module look_disk_request_selector #(
  parameter int POOL_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  entry_index,
  input  logic [15:0] entry_sector,
  input  logic        entry_waiting,
  input  logic [15:0] current_sector,
  input  logic        direction,
  input  logic [3:0]  fallback_index,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  selected_index,
  output logic        used_fallback
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int IW = ldrs_pkg::IDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_DEPTH - 1);

  ldrs_pkg::state_t  state;
  ldrs_pkg::state_t  state_next;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     rd_addr_next;
  logic [15:0]       disk_size;
  logic [POOL_DEPTH-1:0] slot_waiting;
  logic [15:0]       head;
  logic              inward;
  logic [3:0]        fallback;
  ldrs_pkg::sample_t sample;
  ldrs_pkg::cand_t   cand;
  logic [15:0]       rd_sector;

  logic              in_accept;
  logic              start;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic              load;
  logic              out_take;
  logic [3:0]        pick;
  logic              none;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      disk_size <= cfg_data;
    end
  end

  assign in_stall  = state != ldrs_pkg::ST_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign start     = in_accept && (command == ldrs_pkg::CMD_SELECT);
  assign wr_en     = in_accept && (command == ldrs_pkg::CMD_WRITE)
                     && ({5'b0, entry_index} < 9'(POOL_DEPTH));
  assign wr_addr   = AW'(entry_index);
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    state_next   = state;
    rd_addr_next = rd_addr;
    rd_en        = 1'b0;
    load         = 1'b0;
    case (state)
      ldrs_pkg::ST_IDLE: begin
        rd_addr_next = '0;
        if (start) begin
          state_next = ldrs_pkg::ST_SCAN;
        end
      end
      ldrs_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_addr == LAST_ADDR) begin
          state_next = ldrs_pkg::ST_DRAIN;
        end else begin
          rd_addr_next = rd_addr + AW'(1);
        end
      end
      ldrs_pkg::ST_DRAIN: begin
        state_next = ldrs_pkg::ST_FINISH;
      end
      ldrs_pkg::ST_FINISH: begin
        if (!out_valid || out_take) begin
          load       = 1'b1;
          state_next = ldrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ldrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ldrs_pkg::ST_IDLE;
      rd_addr <= '0;
    end else begin
      state   <= state_next;
      rd_addr <= rd_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_waiting <= '0;
    end else if (wr_en) begin
      slot_waiting[wr_addr] <= entry_waiting;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      head     <= current_sector;
      inward   <= direction;
      fallback <= fallback_index;
    end
  end

  // read stage, aligned with the registered memory data
  always_ff @(posedge clk) begin
    sample.waiting <= slot_waiting[rd_addr];
    sample.idx     <= IW'(rd_addr);
    if (rst) begin
      sample.vld <= 1'b0;
    end else begin
      sample.vld <= rd_en;
    end
  end

  ldrs_sector_ram #(
    .DEPTH  (POOL_DEPTH),
    .ADDR_W (AW)
  ) u_sector_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_sector),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_sector)
  );

  ldrs_candidate u_candidate (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .disk_size (disk_size),
    .head      (head),
    .sample    (sample),
    .sector    (rd_sector),
    .cand      (cand)
  );

  assign none = !cand.have_up && !cand.have_down;

  always_comb begin
    if (none) begin
      pick = fallback;
    end else if (!cand.have_up) begin
      pick = cand.down_idx;
    end else if (!cand.have_down) begin
      pick = cand.up_idx;
    end else if (inward) begin
      pick = cand.up_idx;
    end else begin
      pick = cand.down_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      selected_index <= pick;
      used_fallback  <= none;
    end
  end

`ifndef SYNTHESIS
  a_select_starts_scan: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ldrs_pkg::ST_SCAN) && (rd_addr == '0))
    else $error("select request did not start a scan at slot zero");

  a_scan_ends_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ldrs_pkg::ST_SCAN) && (rd_addr == LAST_ADDR)
    |=> (state == ldrs_pkg::ST_DRAIN) && sample.vld)
    else $error("scan did not drain after the last slot");

  a_sample_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    sample.vld |-> (state == ldrs_pkg::ST_SCAN) || (state == ldrs_pkg::ST_DRAIN))
    else $error("slot sample outside a scan");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ldrs_pkg::ST_IDLE))
    else $error("pool written during a scan");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && (used_fallback == $past(none))
    && (selected_index == $past(pick)))
    else $error("result register not loaded with the scan outcome");
`endif

endmodule

/* hw/rtl/ldrs_sector_ram.sv */
// ----------------------------------------------------------------------------
// ldrs_sector_ram
// single write, single read sector store with registered read data
// ----------------------------------------------------------------------------
module ldrs_sector_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [ldrs_pkg::SECTOR_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [ldrs_pkg::SECTOR_W-1:0] rd_data
);

  logic [ldrs_pkg::SECTOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/ldrs_candidate.sv */
// ----------------------------------------------------------------------------
// ldrs_candidate
// tracks the nearest waiting sector above and below the head over a scan
// ----------------------------------------------------------------------------
module ldrs_candidate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ldrs_pkg::SECTOR_W-1:0] disk_size,
  input  logic [ldrs_pkg::SECTOR_W-1:0] head,
  input  ldrs_pkg::sample_t             sample,
  input  logic [ldrs_pkg::SECTOR_W-1:0] sector,
  output ldrs_pkg::cand_t               cand
);

  logic [ldrs_pkg::SECTOR_W:0]   best_up;
  logic [ldrs_pkg::SECTOR_W-1:0] best_down;
  logic                          above;
  logic                          below;
  logic                          up_better;
  logic                          down_better;

  assign above       = sector > head;
  assign below       = sector < head;
  assign up_better   = {1'b0, sector} < best_up;
  assign down_better = !cand.have_down || (sector > best_down);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand.have_up   <= 1'b0;
      cand.have_down <= 1'b0;
    end else if (start) begin
      cand.have_up   <= 1'b0;
      cand.have_down <= 1'b0;
      best_up        <= {1'b0, disk_size} + {{ldrs_pkg::SECTOR_W{1'b0}}, 1'b1};
      best_down      <= '0;
      cand.up_idx    <= '0;
      cand.down_idx  <= '0;
    end else if (sample.vld && sample.waiting) begin
      if (above && up_better) begin
        cand.have_up <= 1'b1;
        best_up      <= {1'b0, sector};
        cand.up_idx  <= sample.idx;
      end
      if (below && down_better) begin
        cand.have_down <= 1'b1;
        best_down      <= sector;
        cand.down_idx  <= sample.idx;
      end
    end
  end

endmodule
